// ===== design/scm_pkg.sv =====
// Shared constants, types and permutation functions for the symmetry canonical minimum block.
`default_nettype none
package scm_pkg;

  localparam int MAX_SYM    = 64;
  localparam int IDX_W      = $clog2(MAX_SYM);
  localparam int CNT_W      = 7;
  localparam int WORD_W     = 16;
  localparam int EDGE_POS   = 12;
  localparam int CORNER_POS = 8;
  localparam int EMAP_W     = 48;
  localparam int CMAP_W     = 24;
  localparam int TRIPLE_W   = 3 * WORD_W;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [CMAP_W-1:0] corner_map;
    logic [EMAP_W-1:0] edge_map;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  function automatic logic [WORD_W-1:0] permute_edges(logic [EMAP_W-1:0] map,
                                                       logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] res;
    res = '0;
    for (int i = 0; i < EDGE_POS; i++) begin
      res[i] = word[map[4*i +: 4]];
    end
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] permute_corners(logic [CMAP_W-1:0] map,
                                                         logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] res;
    res = '0;
    for (int i = 0; i < CORNER_POS; i++) begin
      res[2*i +: 2] = word[{map[3*i +: 3], 1'b0} +: 2];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/scm_ifs.sv =====
// Channel interfaces: item input, result output and configuration write.
`default_nettype none
interface scm_req_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [scm_pkg::IDX_W-1:0]   entry_index;
  logic [scm_pkg::CMAP_W-1:0]  corner_map;
  logic [scm_pkg::EMAP_W-1:0]  edge_map;
  logic [scm_pkg::WORD_W-1:0]  edges_first;
  logic [scm_pkg::WORD_W-1:0]  corner_word;
  logic [scm_pkg::WORD_W-1:0]  edges_second;
  modport source(output valid, mode, entry_index, corner_map, edge_map, edges_first,
                 corner_word, edges_second, input ready);
  modport sink(input valid, mode, entry_index, corner_map, edge_map, edges_first,
               corner_word, edges_second, output ready);
endinterface

interface scm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [scm_pkg::WORD_W-1:0]  lowest_edges_first;
  logic [scm_pkg::WORD_W-1:0]  lowest_corners;
  logic [scm_pkg::WORD_W-1:0]  lowest_edges_second;
  modport source(output valid, lowest_edges_first, lowest_corners, lowest_edges_second,
                 input ready);
  modport sink(input valid, lowest_edges_first, lowest_corners, lowest_edges_second,
               output ready);
endinterface

interface scm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [scm_pkg::CNT_W-1:0]   data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/scm_table.sv =====
// Symmetry table memory: one write port, one read port with registered read data.
`default_nettype none
module scm_table (
  input  wire logic              clk,
  input  wire scm_pkg::wr_req_t  wr_req,
  input  wire scm_pkg::rd_req_t  rd_req,
  output scm_pkg::entry_t        rd_data
);

  scm_pkg::entry_t mem [scm_pkg::MAX_SYM];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data <= mem[rd_req.addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/scm_engine.sv =====
// Query sequencer: walks the table one entry a cycle and keeps the smallest triple.
`default_nettype none
module scm_engine (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [scm_pkg::CNT_W-1:0] num_symmetries,
  scm_req_if.sink                        req,
  scm_rsp_if.source                      rsp,
  output scm_pkg::wr_req_t               wr_req,
  output scm_pkg::rd_req_t               rd_req,
  input  wire scm_pkg::entry_t           rd_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam logic [scm_pkg::CNT_W-1:0] MAX_CNT = scm_pkg::CNT_W'(scm_pkg::MAX_SYM);

  logic [1:0]                      state;
  logic [scm_pkg::CNT_W-1:0]       count;
  logic [scm_pkg::CNT_W-1:0]       issue_idx;
  logic                            data_valid;
  logic                            data_last;
  logic [scm_pkg::WORD_W-1:0]      orig_e0;
  logic [scm_pkg::WORD_W-1:0]      orig_c;
  logic [scm_pkg::WORD_W-1:0]      orig_e1;
  logic [scm_pkg::TRIPLE_W-1:0]    best;
  logic                            out_valid;
  logic [scm_pkg::TRIPLE_W-1:0]    out_data;

  logic                            accept;
  logic                            is_query;
  logic [scm_pkg::CNT_W-1:0]       count_sat;
  logic [scm_pkg::CNT_W-1:0]       issue_cur;
  logic [scm_pkg::CNT_W-1:0]       count_cur;
  logic [scm_pkg::TRIPLE_W-1:0]    cand;
  logic [scm_pkg::TRIPLE_W-1:0]    best_next;
  logic                            out_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign is_query  = (req.mode == scm_pkg::MODE_QUERY);
  assign count_sat = (num_symmetries > MAX_CNT) ? MAX_CNT : num_symmetries;

  always_comb begin
    wr_req.en              = accept && !is_query &&
                             ({1'b0, req.entry_index} < MAX_CNT);
    wr_req.addr            = req.entry_index;
    wr_req.data.corner_map = req.corner_map;
    wr_req.data.edge_map   = req.edge_map;
  end

  assign issue_cur   = accept ? '0 : issue_idx;
  assign count_cur   = accept ? count_sat : count;
  assign rd_req.en   = (accept && is_query && (count_sat != '0)) ||
                       ((state == S_RUN) && (issue_idx < count));
  assign rd_req.addr = issue_cur[scm_pkg::IDX_W-1:0];

  assign cand = {scm_pkg::permute_edges(rd_data.edge_map, orig_e0),
                 scm_pkg::permute_corners(rd_data.corner_map, orig_c),
                 scm_pkg::permute_edges(rd_data.edge_map, orig_e1)};
  assign best_next = (data_valid && (cand < best)) ? cand : best;
  assign out_free  = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      data_valid <= 1'b0;
      data_last  <= 1'b0;
      out_valid  <= 1'b0;
      issue_idx  <= '0;
      count      <= '0;
    end else begin
      data_valid <= rd_req.en;
      data_last  <= rd_req.en && ((issue_cur + 1'b1) == count_cur);
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && is_query) begin
            count     <= count_sat;
            issue_idx <= 7'd1;
            state     <= (count_sat == '0) ? S_DONE : S_RUN;
          end
        end
        S_RUN: begin
          if (rd_req.en) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (data_valid && data_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      orig_e0 <= req.edges_first;
      orig_c  <= req.corner_word;
      orig_e1 <= req.edges_second;
      best    <= {req.edges_first, req.corner_word, req.edges_second};
    end else if (state == S_RUN) begin
      best <= best_next;
    end
    if ((state == S_DONE) && out_free) begin
      out_data <= best;
    end
  end

  assign rsp.valid               = out_valid;
  assign rsp.lowest_edges_first  = out_data[2*scm_pkg::WORD_W +: scm_pkg::WORD_W];
  assign rsp.lowest_corners      = out_data[scm_pkg::WORD_W +: scm_pkg::WORD_W];
  assign rsp.lowest_edges_second = out_data[0 +: scm_pkg::WORD_W];

endmodule
`default_nettype wire

// ===== design/symmetry_canonical_minimum_core.sv =====
// Top level of the symmetry canonical minimum block.
// A load item writes one table entry and leaves the input ready for the next item.
// A query item reads table entries 0 to N-1 through the single read port of the table
// memory, one entry a cycle, and compares each permuted triple against the best so far;
// N is num_symmetries saturated at 64. A query holds the input busy until its result
// moves into the output register, once the previous result is taken; it then sits there,
// so the next item is taken while it waits. Write num_symmetries only while the block is
// idle; every entry below N must be loaded first.
`default_nettype none
module symmetry_canonical_minimum_core (
  input  wire logic  clk,
  input  wire logic  rst,
  scm_req_if.sink    req,
  scm_rsp_if.source  rsp,
  scm_cfg_if.sink    cfg
);

  logic [scm_pkg::CNT_W-1:0] num_symmetries;
  scm_pkg::wr_req_t          wr_req;
  scm_pkg::rd_req_t          rd_req;
  scm_pkg::entry_t           rd_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_symmetries <= '0;
    end else if (cfg.valid && cfg.ready) begin
      num_symmetries <= cfg.data;
    end
  end

  scm_table u_table (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  scm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .num_symmetries (num_symmetries),
    .req            (req),
    .rsp            (rsp),
    .wr_req         (wr_req),
    .rd_req         (rd_req),
    .rd_data        (rd_data)
  );

endmodule
`default_nettype wire

// ===== design/scm_checker.sv =====
// Port-level checker for the symmetry canonical minimum block, bound to the top level.
`default_nettype none
module scm_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        req_valid,
  input wire logic                        req_ready,
  input wire logic                        req_mode,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_ready,
  input wire logic [scm_pkg::WORD_W-1:0]  rsp_e0,
  input wire logic [scm_pkg::WORD_W-1:0]  rsp_c,
  input wire logic [scm_pkg::WORD_W-1:0]  rsp_e1
);

  a_rst_clears_out: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_mode == scm_pkg::MODE_QUERY) |=> !req_ready)
    else $error("input taken right after a query item");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_mode == scm_pkg::MODE_LOAD) |=> req_ready)
    else $error("load item stalled the input");

  a_no_result_on_load: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_mode == scm_pkg::MODE_LOAD && !rsp_valid) |=> !rsp_valid)
    else $error("result appeared after a load item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_e0) && $stable(rsp_c) &&
                                   $stable(rsp_e1)))
    else $error("stalled result changed");

endmodule

bind symmetry_canonical_minimum_core scm_checker u_scm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_mode  (req.mode),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_e0    (rsp.lowest_edges_first),
  .rsp_c     (rsp.lowest_corners),
  .rsp_e1    (rsp.lowest_edges_second)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for symmetry_canonical_minimum_core: directed and random items checked by a predictor.
`timescale 1ns / 1ps
module tb_top;
  import scm_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_WAIT     = 19;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [WORD_W-1:0] edges_first;
    logic [WORD_W-1:0] corners;
    logic [WORD_W-1:0] edges_second;
  } triple_t;

  typedef struct {
    logic              mode;
    logic [IDX_W-1:0]  slot;
    logic [CMAP_W-1:0] cmap;
    logic [EMAP_W-1:0] emap;
    triple_t           words;
  } sym_item_t;

  logic clk;
  logic rst;

  scm_req_if req_ch ();
  scm_rsp_if rsp_ch ();
  scm_cfg_if cfg_ch ();

  symmetry_canonical_minimum_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  logic [CMAP_W-1:0] corner_maps [MAX_SYM];
  logic [EMAP_W-1:0] edge_maps [MAX_SYM];
  int unsigned       sym_count;
  triple_t           lowest_q [$];

  int errors;
  int n_loads;
  int n_queries;
  int n_checked;
  int n_cfg;
  int cycle_cnt;
  bit src_gaps;
  bit snk_gaps;
  int snk_wait;
  int hold_left;
  int hold_len;
  event hold_start;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Predictor

  function automatic logic [WORD_W-1:0] edge_shuffle(logic [EMAP_W-1:0] map,
                                                     logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] r;
    logic [3:0]        src;
    r = '0;
    for (int k = 0; k < EDGE_POS; k++) begin
      src  = map[4*k +: 4];
      r[k] = word[src];
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] corner_shuffle(logic [CMAP_W-1:0] map,
                                                       logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] r;
    logic [WORD_W-1:0] fld;
    logic [2:0]        src;
    r = '0;
    for (int k = 0; k < CORNER_POS; k++) begin
      src          = map[3*k +: 3];
      fld          = word >> (2 * src);
      r[2*k +: 2]  = fld[1:0];
    end
    return r;
  endfunction

  function automatic triple_t apply_symmetry(int slot, triple_t w);
    triple_t r;
    r.edges_first  = edge_shuffle(edge_maps[slot], w.edges_first);
    r.corners      = corner_shuffle(corner_maps[slot], w.corners);
    r.edges_second = edge_shuffle(edge_maps[slot], w.edges_second);
    return r;
  endfunction

  function automatic int active_count();
    return (sym_count > MAX_SYM) ? MAX_SYM : int'(sym_count);
  endfunction

  function automatic triple_t predict_lowest(triple_t w);
    triple_t best;
    triple_t cand;
    best = w;
    for (int k = 0; k < active_count(); k++) begin
      cand = apply_symmetry(k, w);
      if (cand < best) best = cand;
    end
    return best;
  endfunction

  // Stimulus generation

  function automatic logic [EMAP_W-1:0] rand_edge_map();
    logic [3:0]        pos [EDGE_POS];
    logic [3:0]        t;
    logic [EMAP_W-1:0] m;
    int                j;
    m[EMAP_W-1:16] = $urandom;
    m[15:0]        = 16'($urandom);
    if ($urandom_range(0, 9) < 3) return m;
    for (int k = 0; k < EDGE_POS; k++) pos[k] = 4'(k);
    for (int k = EDGE_POS - 1; k > 0; k--) begin
      j      = $urandom_range(0, k);
      t      = pos[k];
      pos[k] = pos[j];
      pos[j] = t;
    end
    for (int k = 0; k < EDGE_POS; k++) m[4*k +: 4] = pos[k];
    return m;
  endfunction

  function automatic logic [CMAP_W-1:0] rand_corner_map();
    logic [2:0]        pos [CORNER_POS];
    logic [2:0]        t;
    logic [CMAP_W-1:0] m;
    int                j;
    m = CMAP_W'($urandom);
    if ($urandom_range(0, 9) < 3) return m;
    for (int k = 0; k < CORNER_POS; k++) pos[k] = 3'(k);
    for (int k = CORNER_POS - 1; k > 0; k--) begin
      j      = $urandom_range(0, k);
      t      = pos[k];
      pos[k] = pos[j];
      pos[j] = t;
    end
    for (int k = 0; k < CORNER_POS; k++) m[3*k +: 3] = pos[k];
    return m;
  endfunction

  function automatic triple_t rand_words();
    triple_t    w;
    logic [1:0] f;
    w.edges_first  = WORD_W'($urandom);
    w.corners      = WORD_W'($urandom);
    w.edges_second = WORD_W'($urandom);
    f              = 2'($urandom);
    case ($urandom_range(0, 3))
      1: begin
        w.edges_first  = w.edges_first & WORD_W'($urandom) & WORD_W'($urandom);
        w.edges_second = w.edges_second & WORD_W'($urandom) & WORD_W'($urandom);
      end
      2: begin
        w.edges_first = '0;
      end
      3: begin
        w.edges_first = '0;
        w.corners     = {CORNER_POS{f}};
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  function automatic sym_item_t load_item(logic [IDX_W-1:0] slot, logic [CMAP_W-1:0] cmap,
                                          logic [EMAP_W-1:0] emap);
    sym_item_t it;
    it.mode  = MODE_LOAD;
    it.slot  = slot;
    it.cmap  = cmap;
    it.emap  = emap;
    it.words = rand_words();
    return it;
  endfunction

  function automatic sym_item_t query_item(logic [WORD_W-1:0] e0, logic [WORD_W-1:0] c,
                                           logic [WORD_W-1:0] e1);
    sym_item_t it;
    it.mode  = MODE_QUERY;
    it.slot  = IDX_W'($urandom);
    it.cmap  = rand_corner_map();
    it.emap  = rand_edge_map();
    it.words = '{edges_first: e0, corners: c, edges_second: e1};
    return it;
  endfunction

  function automatic sym_item_t rand_item(int load_pct);
    sym_item_t it;
    it = load_item(IDX_W'($urandom_range(0, MAX_SYM - 1)), rand_corner_map(),
                   rand_edge_map());
    if ($urandom_range(0, 99) >= load_pct) begin
      it.mode = MODE_QUERY;
      if (active_count() > 0 && $urandom_range(0, 9) < 7)
        it.words = apply_symmetry($urandom_range(0, active_count() - 1), it.words);
    end
    return it;
  endfunction

  // Channel drivers

  task automatic send_item(input sym_item_t it);
    int gap;
    gap = src_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    repeat (gap) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= it.mode;
    req_ch.entry_index  <= it.slot;
    req_ch.corner_map   <= it.cmap;
    req_ch.edge_map     <= it.emap;
    req_ch.edges_first  <= it.words.edges_first;
    req_ch.corner_word  <= it.words.corners;
    req_ch.edges_second <= it.words.edges_second;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (it.mode == MODE_LOAD) begin
      corner_maps[it.slot] = it.cmap;
      edge_maps[it.slot]   = it.emap;
      n_loads++;
    end else begin
      lowest_q.push_back(predict_lowest(it.words));
      n_queries++;
    end
  endtask

  task automatic run_random(input int items, input int load_pct);
    repeat (items) send_item(rand_item(load_pct));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (lowest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input int unsigned n);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= n[CNT_W-1:0];
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sym_count = n;
    n_cfg++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result checking

  task automatic report_mismatch(input string what, input logic [TRIPLE_W-1:0] got,
                                 input logic [TRIPLE_W-1:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH result %0d %s: got %h expected %h", n_checked, what, got, want);
  endtask

  task automatic check_result(input triple_t got);
    triple_t want;
    n_checked++;
    if (lowest_q.size() == 0) begin
      report_mismatch("no item pending", got, '0);
    end else begin
      want = lowest_q.pop_front();
      if (got.edges_first !== want.edges_first)
        report_mismatch("lowest_edges_first", TRIPLE_W'(got.edges_first),
                        TRIPLE_W'(want.edges_first));
      if (got.corners !== want.corners)
        report_mismatch("lowest_corners", TRIPLE_W'(got.corners), TRIPLE_W'(want.corners));
      if (got.edges_second !== want.edges_second)
        report_mismatch("lowest_edges_second", TRIPLE_W'(got.edges_second),
                        TRIPLE_W'(want.edges_second));
    end
  endtask

  always begin
    @(hold_start);
    hold_left = hold_len;
    while (hold_left > 0) begin
      @(posedge clk);
      hold_left--;
    end
  end

  always @(negedge clk) begin
    rsp_ch.ready <= !rst && snk_wait == 0 && hold_left == 0;
  end

  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready) begin
      check_result('{edges_first: rsp_ch.lowest_edges_first,
                     corners: rsp_ch.lowest_corners,
                     edges_second: rsp_ch.lowest_edges_second});
      snk_wait <= snk_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    end else if (snk_wait > 0) begin
      snk_wait <= snk_wait - 1;
    end
  end

  // Tests

  task automatic test_count_zero();
    send_item(query_item(16'h0000, 16'h0000, 16'h0000));
    send_item(query_item(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(query_item(16'h8000, 16'hAAAA, 16'h0001));
  endtask

  task automatic test_directed_table();
    send_item(load_item(0, 24'o76543210, 48'hBA98_7654_3210));
    send_item(load_item(1, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF));
    send_item(load_item(2, 24'o01234567, 48'h0123_4567_89AB));
    send_item(load_item(3, 24'h00_0000, 48'h0000_0000_0000));
    send_item(load_item(IDX_W'(MAX_SYM - 1), rand_corner_map(), rand_edge_map()));
    wait_idle();
    write_count(4);
    send_item(query_item(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(query_item(16'h8000, 16'h0000, 16'h0000));
    send_item(query_item(16'h0001, 16'h1234, 16'h0000));
    send_item(query_item(16'h0000, 16'hC000, 16'h0000));
    send_item(query_item(16'h0800, 16'h0003, 16'h0F0F));
    send_item(query_item(16'h0000, 16'h0000, 16'h8001));
    wait_idle();
    write_count(1);
    send_item(query_item(16'h0800, 16'hE4E4, 16'h0001));
    send_item(query_item(16'hFFFF, 16'h0000, 16'hFFFF));
    wait_idle();
  endtask

  task automatic test_fill_table();
    for (int s = 0; s < MAX_SYM; s++)
      send_item(load_item(IDX_W'(s), rand_corner_map(), rand_edge_map()));
    wait_idle();
  endtask

  task automatic test_full_count();
    write_count(MAX_SYM);
    run_random(450, 20);
    wait_idle();
  endtask

  task automatic test_count_saturation();
    write_count((1 << CNT_W) - 1);
    run_random(120, 20);
    wait_idle();
    write_count(MAX_SYM + 1);
    run_random(80, 20);
    wait_idle();
  endtask

  task automatic test_count_sweep();
    write_count(0);
    run_random(80, 20);
    wait_idle();
    write_count(1);
    run_random(120, 20);
    wait_idle();
    for (int p = 0; p < 4; p++) begin
      src_gaps = (p != 1);
      snk_gaps = (p != 2);
      write_count((p == 3) ? MAX_SYM - 1 : $urandom_range(2, MAX_SYM - 2));
      run_random(120, 25);
      wait_idle();
    end
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    write_count(3);
    hold_len = 400;
    -> hold_start;
    run_random(60, 10);
    wait_idle();
    write_count($urandom_range(8, 24));
    hold_len = 150;
    -> hold_start;
    run_random(40, 10);
    wait_idle();
  endtask

  task automatic test_no_idle();
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    write_count($urandom_range(1, MAX_SYM));
    run_random(150, 20);
    wait_idle();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_LOAD;
    req_ch.entry_index  = '0;
    req_ch.corner_map   = '0;
    req_ch.edge_map     = '0;
    req_ch.edges_first  = '0;
    req_ch.corner_word  = '0;
    req_ch.edges_second = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.data         = '0;
    rsp_ch.ready        = 1'b0;
    src_gaps            = 1'b1;
    snk_gaps            = 1'b1;
    sym_count           = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_count_zero();
    test_directed_table();
    test_fill_table();
    test_full_count();
    test_count_saturation();
    test_count_sweep();
    test_backpressure();
    test_no_idle();
    wait_idle();

    $display("Covered %0d table loads and %0d queries across %0d count settings,",
             n_loads, n_queries, n_cfg);
    $display("including saturated counts and output stalls; %0d results checked, %0d errors.",
             n_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/scm_pkg.sv
design/scm_ifs.sv
design/scm_table.sv
design/scm_engine.sv
design/symmetry_canonical_minimum_core.sv
design/scm_checker.sv
bench/tb_top.sv
